// ===== hw/rtl/dxt_pkg.sv =====
// Shared types and constants of the DXT block texel decoder.
package dxt_pkg;

  localparam logic [2:0] FMT_DXT1  = 3'd0;
  localparam logic [2:0] FMT_DXT1A = 3'd1;
  localparam logic [2:0] FMT_DXT3  = 3'd2;
  localparam logic [2:0] FMT_DXT5  = 3'd3;
  localparam logic [2:0] FMT_DXN   = 3'd4;
  localparam logic [2:0] FMT_DXT5A = 3'd5;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [63:0] first_half;
    logic [63:0] second_half;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] texel_col;
    logic [1:0] texel_row;
    logic       last_texel;
  } out_t;

  // classified block, as held between front and back end
  typedef struct packed {
    logic [2:0]       fmt;
    logic             four_col;
    logic [2:0][7:0]  ce0;
    logic [2:0][7:0]  ce1;
    logic [31:0]      cidx;
    logic [1:0][7:0]  a0;
    logic [1:0][7:0]  a1;
    logic [1:0]       amode8;
    logic [1:0][47:0] aidx;
    logic [63:0]      expl;
  } blk_t;

endpackage

// ===== hw/rtl/dxt_front.sv =====
// Front end: accepts blocks, drops undefined formats, expands endpoints.
module dxt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [2:0]    block_format,
  input  logic          in_valid,
  output logic          in_ready,
  input  dxt_pkg::in_t  in_data,
  output logic          push,
  input  logic          q_full,
  output dxt_pkg::blk_t push_data
);
  import dxt_pkg::*;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  logic        f_valid;
  blk_t        f_blk;
  blk_t        blk_next;
  logic [63:0] cblk;
  logic [63:0] h0;
  logic [63:0] h1;
  logic        fmt_ok;
  logic        accept;

  assign h0       = in_data.first_half;
  assign h1       = in_data.second_half;
  assign fmt_ok   = block_format <= FMT_DXT5A;
  assign in_ready = !f_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = f_valid && !q_full;
  assign push_data = f_blk;

  always_comb begin
    cblk = (block_format <= FMT_DXT1A) ? h0 : h1;
    blk_next.fmt      = block_format;
    blk_next.four_col = cblk[15:0] > cblk[31:16];
    blk_next.ce0[0]   = widen5(cblk[15:11]);
    blk_next.ce0[1]   = widen6(cblk[10:5]);
    blk_next.ce0[2]   = widen5(cblk[4:0]);
    blk_next.ce1[0]   = widen5(cblk[31:27]);
    blk_next.ce1[1]   = widen6(cblk[26:21]);
    blk_next.ce1[2]   = widen5(cblk[20:16]);
    blk_next.cidx     = cblk[63:32];
    blk_next.a0[0]    = h0[7:0];
    blk_next.a1[0]    = h0[15:8];
    blk_next.a0[1]    = h1[7:0];
    blk_next.a1[1]    = h1[15:8];
    blk_next.amode8[0] = h0[7:0] > h0[15:8];
    blk_next.amode8[1] = h1[7:0] > h1[15:8];
    blk_next.aidx[0]  = h0[63:16];
    blk_next.aidx[1]  = h1[63:16];
    blk_next.expl     = h0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= fmt_ok;
    end else if (!q_full) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_blk <= blk_next;
    end
  end

endmodule

// ===== hw/rtl/dxt_queue.sv =====
// Short block queue between front and back end.
module dxt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dxt_pkg::blk_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output dxt_pkg::blk_t head_data
);
  import dxt_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  blk_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = count == FullCnt;
  assign head_valid = count != '0;
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/dxt_back.sv =====
// Back end: walks the sixteen texels of the head block, one per cycle unless the output stalls.
module dxt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  dxt_pkg::blk_t head_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output dxt_pkg::out_t out_data
);
  import dxt_pkg::*;

  typedef enum logic [2:0] {
    DIV1,
    DIV2,
    DIV3,
    DIV5,
    DIV7
  } div_t;

  typedef struct packed {
    logic [10:0] num;
    div_t        op;
  } term_t;

  function automatic term_t const_term(input logic [7:0] v);
    term_t t;
    t.num = {3'b000, v};
    t.op  = DIV1;
    return t;
  endfunction

  function automatic term_t colour_term(input logic [7:0] e0, input logic [7:0] e1,
                                        input logic four, input logic [1:0] s);
    term_t       t;
    logic [10:0] x0;
    logic [10:0] x1;
    x0 = {3'b000, e0};
    x1 = {3'b000, e1};
    unique case (s)
      2'd0: t = const_term(e0);
      2'd1: t = const_term(e1);
      2'd2: begin
        t.num = four ? (x0 + x0 + x1) : (x0 + x1);
        t.op  = four ? DIV3 : DIV2;
      end
      default: begin
        t.num = four ? (x0 + x1 + x1) : 11'd0;
        t.op  = four ? DIV3 : DIV1;
      end
    endcase
    return t;
  endfunction

  function automatic term_t alpha_term(input logic [7:0] a0, input logic [7:0] a1,
                                       input logic mode8, input logic [2:0] j);
    term_t       t;
    logic [10:0] k;
    logic [10:0] x0;
    logic [10:0] x1;
    k  = {8'd0, j} - 11'd1;
    x0 = {3'b000, a0};
    x1 = {3'b000, a1};
    priority if (j == 3'd0) begin
      t = const_term(a0);
    end else if (j == 3'd1) begin
      t = const_term(a1);
    end else if (mode8) begin
      t.num = (11'd7 - k) * x0 + k * x1;
      t.op  = DIV7;
    end else if (j <= 3'd5) begin
      t.num = (11'd5 - k) * x0 + k * x1;
      t.op  = DIV5;
    end else if (j == 3'd6) begin
      t = const_term(8'd0);
    end else begin
      t = const_term(8'd255);
    end
    return t;
  endfunction

  // constant divisors by reciprocal multiply, exact for the ranges in use
  function automatic logic [7:0] finish(input term_t t);
    logic [23:0] p;
    logic [7:0]  q;
    p = '0;
    unique case (t.op)
      DIV2: q = t.num[8:1];
      DIV3: begin
        p = 24'(t.num) * 24'd683;
        q = p[18:11];
      end
      DIV5: begin
        p = 24'(t.num) * 24'd1639;
        q = p[20:13];
      end
      DIV7: begin
        p = 24'(t.num) * 24'd2341;
        q = p[21:14];
      end
      default: q = t.num[7:0];
    endcase
    return q;
  endfunction

  logic [3:0]      idx;
  logic            s1_valid;
  term_t [3:0]     s1_term;
  logic [3:0]      s1_idx;
  term_t [3:0]     term_next;
  logic            advance;
  logic [1:0]      cs;
  logic [5:0]      ai;
  logic [2:0]      j0;
  logic [2:0]      j1;
  logic [3:0]      nib;
  term_t [3:0]     cterm;
  term_t [1:0]     aterm;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && head_valid && (idx == 4'd15);

  always_comb begin
    cs  = head_data.cidx[{idx, 1'b0} +: 2];
    ai  = {1'b0, idx, 1'b0} + {2'b00, idx};
    j0  = head_data.aidx[0][ai +: 3];
    j1  = head_data.aidx[1][ai +: 3];
    nib = head_data.expl[{idx, 2'b00} +: 4];
    for (int c = 0; c < 3; c++) begin
      cterm[c] = colour_term(head_data.ce0[c], head_data.ce1[c], head_data.four_col, cs);
    end
    cterm[3] = const_term((cs == 2'd3 && !head_data.four_col) ? 8'd0 : 8'd255);
    aterm[0] = alpha_term(head_data.a0[0], head_data.a1[0], head_data.amode8[0], j0);
    aterm[1] = alpha_term(head_data.a0[1], head_data.a1[1], head_data.amode8[1], j1);
    term_next[0] = const_term(8'd0);
    term_next[1] = const_term(8'd0);
    term_next[2] = const_term(8'd0);
    term_next[3] = const_term(8'd0);
    priority if (head_data.fmt == FMT_DXT1 || head_data.fmt == FMT_DXT1A) begin
      term_next = cterm;
    end else if (head_data.fmt == FMT_DXT3) begin
      term_next    = cterm;
      term_next[3] = const_term({nib, nib});
    end else if (head_data.fmt == FMT_DXT5) begin
      term_next    = cterm;
      term_next[3] = aterm[0];
    end else if (head_data.fmt == FMT_DXN) begin
      term_next[0] = aterm[0];
      term_next[1] = aterm[1];
    end else begin
      term_next[3] = aterm[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= head_valid;
      out_valid <= s1_valid;
      if (head_valid) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_term             <= term_next;
      s1_idx              <= idx;
      out_data.red        <= finish(s1_term[0]);
      out_data.green      <= finish(s1_term[1]);
      out_data.blue       <= finish(s1_term[2]);
      out_data.alpha      <= finish(s1_term[3]);
      out_data.texel_col  <= s1_idx[1:0];
      out_data.texel_row  <= s1_idx[3:2];
      out_data.last_texel <= s1_idx == 4'd15;
    end
  end

endmodule

// ===== hw/rtl/dxt_block_texel_decoder.sv =====
// Top level of the DXT block texel decoder.
// Decodes one 16-byte (or 8-byte) compressed 4x4 block per transfer into
// sixteen RGBA8 texels, row-major, the sixteenth flagged by last_texel.
// The back end emits one texel per cycle from its texel counter, so blocks
// stream back to back at one texel per clock while out_ready stays high.
// A block passes the front-end register and a two-entry queue; each texel
// then passes the back end's term and output registers. block_format is
// sampled when a block is taken; format codes 6 and 7 take the block and
// produce no texels. Write cfg_data only while no block is in flight.
module dxt_block_texel_decoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  dxt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dxt_pkg::out_t out_data
);
  import dxt_pkg::*;

  logic [2:0] block_format;
  logic       push;
  logic       q_full;
  blk_t       push_data;
  logic       pop;
  logic       head_valid;
  blk_t       head_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_DXT1;
    end else if (cfg_valid) begin
      block_format <= cfg_data;
    end
  end

  dxt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .block_format (block_format),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .push         (push),
    .q_full       (q_full),
    .push_data    (push_data)
  );

  dxt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  dxt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
